// ----- hw/rtl/frm_pkg.sv -----
// Package: shared types, widths and constants of the flow usage rate meter.
package frm_pkg;

	// Field and datapath widths
	localparam int RATE_BITS  = 48;
	localparam int FRAC_BITS  = 16;
	localparam int Q_W        = RATE_BITS + FRAC_BITS;
	localparam int TIME_W     = 63;
	localparam int BYTES_W    = 62;
	localparam int STATUS_W   = 2;
	localparam int HALF_W     = 32;
	localparam int MAC_W      = 3 * HALF_W;
	localparam int NS_W       = 30;
	localparam int PROD_W     = BYTES_W + NS_W;
	localparam int BYTE_SHIFT = 3;
	localparam int DIVIDEND_W = PROD_W + BYTE_SHIFT;
	localparam int DIV_HI_W   = DIVIDEND_W - RATE_BITS;
	localparam int DIV_CNT_W  = $clog2(RATE_BITS);
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_W      = 1;

	// Arithmetic constants
	localparam logic [HALF_W-1:0] NS_PER_SEC  = HALF_W'(1000000000);
	localparam logic [HALF_W-1:0] ALPHA_Q16   = HALF_W'(19661);
	localparam logic [HALF_W-1:0] KEEP_Q16    = HALF_W'(45875);
	localparam logic [MAC_W-1:0]  ROUND_HALF  = MAC_W'(32768);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_ENABLE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEAF_MODE     = 1'd1;

	// Result status codes
	localparam logic [STATUS_W-1:0] STATUS_UPDATED  = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_STALE    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_WAITING  = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_BACKWARD = 2'd3;

	typedef struct packed {
		logic [TIME_W-1:0]    time_ns;
		logic [RATE_BITS-1:0] child_rate_bps;
		logic [BYTES_W-1:0]   cum_hipri_bytes;
		logic [BYTES_W-1:0]   cum_lopri_bytes;
		logic [BYTES_W-1:0]   cum_total_bytes;
		logic                 lopri_flag;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [RATE_BITS-1:0] ewma_rate_bps;
		logic                 rate_valid;
		logic                 currently_lopri;
	} out_item_t;

	// Multiply-accumulate command
	typedef struct packed {
		logic              en;
		logic              clear;
		logic              round;
		logic              upper;
		logic [HALF_W-1:0] a;
		logic [HALF_W-1:0] b;
	} mac_cmd_t;

	// Divider command and status
	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [TIME_W-1:0]     divisor;
	} div_cmd_t;

	typedef struct packed {
		logic                 busy;
		logic                 done;
		logic [RATE_BITS-1:0] quot;
	} div_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EVAL,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_PICK,
		ST_EWMA_M_LO,
		ST_EWMA_M_HI,
		ST_EWMA_O_LO,
		ST_EWMA_O_HI,
		ST_EWMA_DONE,
		ST_EMIT
	} state_t;

	// Add two byte counters, saturating at the counter maximum
	function automatic logic [BYTES_W-1:0] sat_add_bytes(input logic [BYTES_W-1:0] a,
			input logic [BYTES_W-1:0] b);
		logic [BYTES_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[BYTES_W] ? {BYTES_W{1'b1}} : s[BYTES_W-1:0];
	endfunction

endpackage

// ----- hw/rtl/frm_mac.sv -----
// Shared 32x32 multiply-accumulate unit with an optional upper-half shift.
module frm_mac
	import frm_pkg::*;
(
	input  logic            clk,
	input  mac_cmd_t        cmd,
	output logic [MAC_W-1:0] acc
);

	logic [MAC_W-1:0]      acc_q;
	logic [2*HALF_W-1:0]   prod;
	logic [MAC_W-1:0]      shifted;
	logic [MAC_W-1:0]      base;

	// Form the partial product and place it in the low or upper half
	always_comb begin
		prod    = cmd.a * cmd.b;
		shifted = cmd.upper ? {prod, {HALF_W{1'b0}}} : {{HALF_W{1'b0}}, prod};
		if (cmd.clear) begin
			base = cmd.round ? ROUND_HALF : '0;
		end else begin
			base = acc_q;
		end
	end

	// Accumulate
	always_ff @(posedge clk) begin
		if (cmd.en) begin
			acc_q <= base + shifted;
		end
	end

	assign acc = acc_q;

endmodule

// ----- hw/rtl/frm_div.sv -----
// Restoring divider: one quotient bit per cycle, saturating quotient.
module frm_div
	import frm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  div_cmd_t  cmd,
	output div_stat_t stat
);

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [TIME_W-1:0]     rem_q;
	logic [RATE_BITS-1:0]  lo_q;
	logic [TIME_W-1:0]     start_hi;
	logic [TIME_W:0]       rem_shift;
	logic [TIME_W:0]       rem_diff;
	logic                  fits;
	logic                  overflow;

	// Step logic: shift in one dividend bit, trial subtract
	always_comb begin
		start_hi  = {{(TIME_W-DIV_HI_W){1'b0}}, cmd.dividend[DIVIDEND_W-1:RATE_BITS]};
		overflow  = start_hi >= cmd.divisor;
		rem_shift = {rem_q, lo_q[RATE_BITS-1]};
		rem_diff  = rem_shift - {1'b0, cmd.divisor};
		fits      = rem_shift >= {1'b0, cmd.divisor};
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= !overflow;
				done_q <= overflow;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(RATE_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= start_hi;
			lo_q  <= overflow ? {RATE_BITS{1'b1}} : cmd.dividend[RATE_BITS-1:0];
		end else if (busy_q) begin
			rem_q <= fits ? rem_diff[TIME_W-1:0] : rem_shift[TIME_W-1:0];
			lo_q  <= {lo_q[RATE_BITS-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign stat.quot = lo_q;

endmodule

// ----- hw/rtl/flow_usage_rate_meter_top.sv -----
// Top level: usage report sequencer, flow state and result register.
//
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------
//  in        | in_valid / in_stall  | in_data   (in_item_t)
//  out       | out_valid / out_stall| out_data  (out_item_t)
//  cfg       | cfg_we               | cfg_index, cfg_data
//
// Steps per report: stale, backward or waiting reports go from evaluation straight to emit;
// a copied rate adds a pick step, a blended rate adds four multiply-accumulate steps and a
// write-back; a mean rate first adds two multiply steps, divider start, quotient bits, done.
// in_stall is high from acceptance until the result is loaded into the output register;
// a result held by out_stall holds the sequencer in its last step.
// arst_n clears control and flow state; registers reset to smoothing on, aggregate mode.
module flow_usage_rate_meter_top
	import frm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	state_t state_q, state_d;

	// Configuration
	logic smooth_en_q;
	logic leaf_mode_q;

	// Flow state
	logic [TIME_W-1:0]    last_time_q;
	logic [BYTES_W-1:0]   total_q;
	logic [BYTES_W-1:0]   hipri_q;
	logic [BYTES_W-1:0]   lopri_q;
	logic                 seen_q;
	logic                 have_rate_q;
	logic [Q_W-1:0]       smoothed_q;
	logic                 lopri_state_q;

	// Working registers for one transaction
	in_item_t             item_q;
	logic [STATUS_W-1:0]  status_q;
	logic [BYTES_W-1:0]   delta_q;
	logic [TIME_W-1:0]    dt_q;
	logic [RATE_BITS-1:0] measured_q;

	// Result register
	out_item_t            out_q;
	logic                 out_valid_q;

	// Evaluation of the captured report
	logic                 stale;
	logic                 backward;
	logic [BYTES_W-1:0]   new_hi;
	logic [BYTES_W-1:0]   new_lo;
	logic [BYTES_W-1:0]   new_total;
	logic [BYTES_W-1:0]   leaf_delta;
	logic                 lopri_only;
	logic [BYTES_W-1:0]   delta;
	logic [TIME_W-1:0]    dt;
	logic                 go_on;

	// Sequencer outputs
	logic                 accept;
	logic                 emit_load;
	logic                 commit;
	logic                 take_quot;
	logic                 copy_rate;
	logic                 blend_done;
	mac_cmd_t             mac_cmd;
	div_cmd_t             div_cmd;
	logic [MAC_W-1:0]     mac_acc;
	div_stat_t            div_stat;
	logic [Q_W-1:0]       mq;

	frm_mac u_mac (
		.clk (clk),
		.cmd (mac_cmd),
		.acc (mac_acc)
	);

	frm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (div_cmd),
		.stat   (div_stat)
	);

	assign mq = {measured_q, {FRAC_BITS{1'b0}}};

	// Check the report against the stored flow state
	always_comb begin
		stale      = item_q.time_ns < last_time_q;
		leaf_delta = item_q.cum_total_bytes - total_q;
		if (leaf_mode_q) begin
			backward  = item_q.cum_total_bytes < total_q;
			new_hi    = item_q.lopri_flag ? hipri_q : sat_add_bytes(hipri_q, leaf_delta);
			new_lo    = item_q.lopri_flag ? sat_add_bytes(lopri_q, leaf_delta) : lopri_q;
			new_total = item_q.cum_total_bytes;
		end else begin
			backward  = (item_q.cum_hipri_bytes < hipri_q) ||
			            (item_q.cum_lopri_bytes < lopri_q);
			new_hi    = item_q.cum_hipri_bytes;
			new_lo    = item_q.cum_lopri_bytes;
			new_total = sat_add_bytes(item_q.cum_hipri_bytes, item_q.cum_lopri_bytes);
		end
		lopri_only = (new_hi == hipri_q) && (new_lo > lopri_q);
		delta      = (new_total >= total_q) ? (new_total - total_q) : '0;
		dt         = item_q.time_ns - last_time_q;
		go_on      = !stale && !backward;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				priority if (!go_on) begin
					state_d = ST_EMIT;
				end else if (!seen_q) begin
					state_d = (item_q.child_rate_bps == '0) ? ST_EMIT : ST_PICK;
				end else if (dt != '0) begin
					state_d = ST_MUL_LO;
				end else begin
					state_d = ST_PICK;
				end
			end
			ST_MUL_LO:    state_d = ST_MUL_HI;
			ST_MUL_HI:    state_d = ST_DIV_START;
			ST_DIV_START: state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (div_stat.done) begin
					state_d = ST_PICK;
				end
			end
			ST_PICK: begin
				state_d = (!have_rate_q || !smooth_en_q) ? ST_EMIT : ST_EWMA_M_LO;
			end
			ST_EWMA_M_LO: state_d = ST_EWMA_M_HI;
			ST_EWMA_M_HI: state_d = ST_EWMA_O_LO;
			ST_EWMA_O_LO: state_d = ST_EWMA_O_HI;
			ST_EWMA_O_HI: state_d = ST_EWMA_DONE;
			ST_EWMA_DONE: state_d = ST_EMIT;
			ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_stall         = 1'b1;
		accept           = 1'b0;
		emit_load        = 1'b0;
		commit           = 1'b0;
		take_quot        = 1'b0;
		copy_rate        = 1'b0;
		blend_done       = 1'b0;
		mac_cmd          = '0;
		div_cmd.start    = 1'b0;
		div_cmd.dividend = {mac_acc[PROD_W-1:0], {BYTE_SHIFT{1'b0}}};
		div_cmd.divisor  = dt_q;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				accept   = in_valid;
			end
			ST_EVAL: begin
				commit = go_on;
			end
			ST_MUL_LO: begin
				mac_cmd.en    = 1'b1;
				mac_cmd.clear = 1'b1;
				mac_cmd.a     = delta_q[HALF_W-1:0];
				mac_cmd.b     = NS_PER_SEC;
			end
			ST_MUL_HI: begin
				mac_cmd.en    = 1'b1;
				mac_cmd.upper = 1'b1;
				mac_cmd.a     = {{(2*HALF_W-BYTES_W){1'b0}}, delta_q[BYTES_W-1:HALF_W]};
				mac_cmd.b     = NS_PER_SEC;
			end
			ST_DIV_START: begin
				div_cmd.start = 1'b1;
			end
			ST_DIV_WAIT: begin
				take_quot = div_stat.done;
			end
			ST_PICK: begin
				copy_rate = !have_rate_q || !smooth_en_q;
			end
			ST_EWMA_M_LO: begin
				mac_cmd.en    = 1'b1;
				mac_cmd.clear = 1'b1;
				mac_cmd.round = 1'b1;
				mac_cmd.a     = mq[HALF_W-1:0];
				mac_cmd.b     = ALPHA_Q16;
			end
			ST_EWMA_M_HI: begin
				mac_cmd.en    = 1'b1;
				mac_cmd.upper = 1'b1;
				mac_cmd.a     = mq[Q_W-1:HALF_W];
				mac_cmd.b     = ALPHA_Q16;
			end
			ST_EWMA_O_LO: begin
				mac_cmd.en = 1'b1;
				mac_cmd.a  = smoothed_q[HALF_W-1:0];
				mac_cmd.b  = KEEP_Q16;
			end
			ST_EWMA_O_HI: begin
				mac_cmd.en    = 1'b1;
				mac_cmd.upper = 1'b1;
				mac_cmd.a     = smoothed_q[Q_W-1:HALF_W];
				mac_cmd.b     = KEEP_Q16;
			end
			ST_EWMA_DONE: begin
				blend_done = 1'b1;
			end
			ST_EMIT: begin
				emit_load = !out_valid_q || !out_stall;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// State register and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			smooth_en_q <= 1'b1;
			leaf_mode_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_SMOOTH_ENABLE: smooth_en_q <= cfg_data[0];
					CFG_LEAF_MODE:     leaf_mode_q <= cfg_data[0];
					default:           leaf_mode_q <= leaf_mode_q;
				endcase
			end
		end
	end

	// Flow state: counters and timestamp advance once a report passes its checks; the smoothed rate on copy or blend
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q   <= '0;
			total_q       <= '0;
			hipri_q       <= '0;
			lopri_q       <= '0;
			seen_q        <= 1'b0;
			have_rate_q   <= 1'b0;
			smoothed_q    <= '0;
			lopri_state_q <= 1'b0;
		end else begin
			if (commit) begin
				last_time_q   <= item_q.time_ns;
				total_q       <= new_total;
				hipri_q       <= new_hi;
				lopri_q       <= new_lo;
				seen_q        <= 1'b1;
				lopri_state_q <= lopri_only;
			end
			if (copy_rate) begin
				smoothed_q  <= mq;
				have_rate_q <= 1'b1;
			end else if (blend_done) begin
				smoothed_q <= mac_acc[Q_W+FRAC_BITS-1:FRAC_BITS];
			end
		end
	end

	// Transaction working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_data;
		end
		if (state_q == ST_EVAL) begin
			delta_q    <= delta;
			dt_q       <= dt;
			measured_q <= item_q.child_rate_bps;
			priority if (stale) begin
				status_q <= STATUS_STALE;
			end else if (backward) begin
				status_q <= STATUS_BACKWARD;
			end else if (!seen_q && (item_q.child_rate_bps == '0)) begin
				status_q <= STATUS_WAITING;
			end else begin
				status_q <= STATUS_UPDATED;
			end
		end
		if (take_quot && (div_stat.quot > measured_q)) begin
			measured_q <= div_stat.quot;
		end
	end

	// Result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_q.status          <= status_q;
			out_q.ewma_rate_bps   <= smoothed_q[Q_W-1:FRAC_BITS];
			out_q.rate_valid      <= have_rate_q;
			out_q.currently_lopri <= lopri_state_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
